@@ rtl/vtd_pkg.sv @@
package vtd_pkg;

    // Field and register widths
    localparam int DATA_W    = 32;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = $clog2(NUM_REGS);

    // Matrix shape: rows 0..2 scale the point, row 3 translates
    localparam int NUM_ROWS  = 4;
    localparam int NUM_COLS  = 4;
    localparam int NUM_LANES = 3;
    localparam int W_COL     = 3;

    // Arithmetic widths of the transform
    localparam int PROD_W    = 2 * DATA_W;
    localparam int HALF_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = PROD_W;

    // Pipeline depth: transform stages, then the divider lane
    localparam int XFORM_STAGES = 4;
    localparam int DIV_STEPS    = DATA_W;
    localparam int LANE_LAT     = DIV_STEPS + 2;

    // Saturation codes
    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Sign and magnitude of one homogeneous coordinate
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

endpackage

@@ rtl/vtd_div_lane.sv @@
module vtd_div_lane
    import vtd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              adv,
    input  sm_t               num,
    input  sm_t               den,
    output logic [DATA_W-1:0] quot,
    output logic              ovf
);

    localparam int SHIFT = DATA_W - FRAC_BITS;

    typedef struct packed {
        logic big;
        logic neg;
        logic dz;
        logic nz;
        logic nneg;
    } lane_flags_t;

    // Stage registers: index 0 is the setup stage, index k+1 follows step k
    logic [MAG_W-1:0]  rem_reg [DIV_STEPS+1];
    logic [DATA_W-1:0] wq_reg  [DIV_STEPS+1];
    logic [MAG_W-1:0]  den_reg [DIV_STEPS+1];
    lane_flags_t       flg_reg [DIV_STEPS+1];

    logic [DATA_W-1:0] quot_reg;
    logic              ovf_reg;

    // Setup: check the quotient range, split the scaled dividend
    logic [MAG_W+SHIFT-1:0] num_ext;
    logic [MAG_W+SHIFT-1:0] den_ext;
    lane_flags_t            flg_next;

    assign num_ext = {{SHIFT{1'b0}}, num.mag};
    assign den_ext = {den.mag, {SHIFT{1'b0}}};

    always_comb
    begin
        flg_next.big  = num_ext >= den_ext;
        flg_next.neg  = num.neg ^ den.neg;
        flg_next.dz   = den.mag == '0;
        flg_next.nz   = num.mag == '0;
        flg_next.nneg = num.neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num.mag >> SHIFT;
            wq_reg[0]  <= {num.mag[SHIFT-1:0], {FRAC_BITS{1'b0}}};
            den_reg[0] <= den.mag;
            flg_reg[0] <= flg_next;
        end
    end

    // One restoring step per stage: dividend bits leave the top of wq,
    // quotient bits enter at the bottom
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           take;

        assign trial = {rem_reg[k], wq_reg[k][DATA_W-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign take  = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                wq_reg[k+1]  <= {wq_reg[k][DATA_W-2:0], take};
                den_reg[k+1] <= den_reg[k];
                flg_reg[k+1] <= flg_reg[k];
            end
        end
    end

    // Apply sign and saturate
    logic [DATA_W-1:0] q_last;
    lane_flags_t       f_last;
    logic [DATA_W-1:0] quot_next;
    logic              ovf_next;

    assign q_last = wq_reg[DIV_STEPS];
    assign f_last = flg_reg[DIV_STEPS];

    always_comb
    begin
        quot_next = q_last;
        ovf_next  = 1'b0;
        if (f_last.dz)
        begin
            if (f_last.nz)
            begin
                quot_next = '0;
            end
            else
            begin
                quot_next = f_last.nneg ? SAT_NEG : SAT_POS;
            end
        end
        else if (f_last.neg)
        begin
            if (f_last.big || (q_last > SAT_NEG))
            begin
                quot_next = SAT_NEG;
                ovf_next  = 1'b1;
            end
            else
            begin
                quot_next = '0 - q_last;
            end
        end
        else if (f_last.big || q_last[DATA_W-1])
        begin
            quot_next = SAT_POS;
            ovf_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quot_reg <= quot_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

@@ rtl/vertex_transform_divide_core.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_ready   | point_x, point_y, point_z (signed fixed)
// output   | out_valid / out_ready | proj_x, proj_y, proj_z, w_zero, overflowed
// config   | cfg_write             | cfg_index, cfg_data (two entries of one matrix row)
//
// One request enters per cycle unless the pipeline is held; each taken request
// passes through four transform stages, then 32 divider steps (one
// quotient bit per stage) with a setup and a saturation stage.
// Reset loads the identity matrix and empties the pipeline.
// When a result waits and out_ready is low, the whole pipeline holds and
// in_ready drops; it moves again in the cycle the result is taken.
module vertex_transform_divide_core
    import vtd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] point_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] proj_x,
    output logic signed [DATA_W-1:0] proj_y,
    output logic signed [DATA_W-1:0] proj_z,
    output logic                     w_zero,
    output logic                     overflowed,
    input  logic                     cfg_write,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [REG_W-1:0]         cfg_data
);

    localparam int TR_W  = DATA_W + FRAC_BITS;
    localparam int DEPTH = XFORM_STAGES + LANE_LAT;
    localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] ONE_HI = ONE_LO << DATA_W;

    // Identity value of register i: row i/2, columns 2*(i%2) and 2*(i%2)+1
    function automatic logic [REG_W-1:0] ident_val(input int i);
        int r;
        int k;
        r = i / 2;
        k = i % 2;
        if (r == 2 * k)
        begin
            return ONE_LO;
        end
        else if (r == 2 * k + 1)
        begin
            return ONE_HI;
        end
        return '0;
    endfunction

    logic adv;
    logic [REG_W-1:0] matrix_reg [NUM_REGS];
    logic [DEPTH-1:0] valid_reg;

    // Hold everything while a result waits
    assign adv      = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;

    // Matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                matrix_reg[i] <= ident_val(i);
            end
        end
        else if (cfg_write)
        begin
            matrix_reg[cfg_index] <= cfg_data;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    // Matrix entries and point coordinates
    logic signed [DATA_W-1:0] entry [NUM_ROWS][NUM_COLS];
    logic signed [DATA_W-1:0] pt    [NUM_LANES];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < NUM_COLS; c++)
        begin : g_col
            assign entry[r][c] = matrix_reg[2*r + c/2][(c%2)*DATA_W +: DATA_W];
        end
    end

    // Transform pipeline per column
    logic signed [PROD_W-1:0] prod_reg  [NUM_COLS][NUM_LANES];
    logic signed [TR_W-1:0]   trans_reg [NUM_COLS];
    logic signed [HALF_W-1:0] half_a_reg[NUM_COLS];
    logic signed [HALF_W-1:0] half_b_reg[NUM_COLS];
    logic signed [SUM_W-1:0]  hsum_reg  [NUM_COLS];
    sm_t                      sm_reg    [NUM_COLS];

    for (genvar c = 0; c < NUM_COLS; c++)
    begin : g_xform
        logic signed [SUM_W-1:0] hneg;

        assign hneg = -hsum_reg[c];

        for (genvar r = 0; r < NUM_LANES; r++)
        begin : g_mul
            // Stage 1: one product per matrix entry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[c][r] <= PROD_W'(pt[r]) * PROD_W'(entry[r][c]);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // Stage 1: translation scaled to the product format
                trans_reg[c]  <= {entry[W_COL][c], {FRAC_BITS{1'b0}}};
                // Stage 2: pairwise sums
                half_a_reg[c] <= HALF_W'(prod_reg[c][0]) + HALF_W'(prod_reg[c][1]);
                half_b_reg[c] <= HALF_W'(prod_reg[c][2]) + HALF_W'(trans_reg[c]);
                // Stage 3: full homogeneous coordinate
                hsum_reg[c]   <= SUM_W'(half_a_reg[c]) + SUM_W'(half_b_reg[c]);
                // Stage 4: sign and magnitude
                sm_reg[c].neg <= hsum_reg[c][SUM_W-1];
                sm_reg[c].mag <= hsum_reg[c][SUM_W-1] ? hneg[MAG_W-1:0]
                                                      : hsum_reg[c][MAG_W-1:0];
            end
        end
    end

    // Carry the zero-w flag alongside the divider lanes
    logic wz_reg [LANE_LAT+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wz_reg[0] <= hsum_reg[W_COL] == '0;
            for (int j = 1; j <= LANE_LAT; j++)
            begin
                wz_reg[j] <= wz_reg[j-1];
            end
        end
    end

    // Divider lanes for x, y and z
    logic [DATA_W-1:0]    quot [NUM_LANES];
    logic [NUM_LANES-1:0] lane_ovf;

    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        vtd_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .adv  (adv),
            .num  (sm_reg[c]),
            .den  (sm_reg[W_COL]),
            .quot (quot[c]),
            .ovf  (lane_ovf[c])
        );
    end

    assign out_valid  = valid_reg[DEPTH-1];
    assign proj_x     = quot[0];
    assign proj_y     = quot[1];
    assign proj_z     = quot[2];
    assign w_zero     = wz_reg[LANE_LAT];
    assign overflowed = |lane_ovf;

endmodule

@@ rtl/vtd_checker.sv @@
module vtd_checker
    import vtd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [DATA_W-1:0] point_x,
    input logic signed [DATA_W-1:0] point_y,
    input logic signed [DATA_W-1:0] point_z,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] proj_x,
    input logic signed [DATA_W-1:0] proj_y,
    input logic signed [DATA_W-1:0] proj_z,
    input logic                     w_zero,
    input logic                     overflowed,
    input logic                     cfg_write,
    input logic [IDX_W-1:0]         cfg_index,
    input logic [REG_W-1:0]         cfg_data
);

    // A waiting result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(proj_x)
                                    && $stable(proj_y) && $stable(proj_z))
        else $error("result changed while stalled");

    // A stalled output stalls the input side
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while pipeline held");

    // Zero w never reports overflow
    a_wz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_zero |-> !overflowed)
        else $error("overflow flagged with zero w");

    // Zero w gives a saturated or zero x coordinate
    a_wz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_zero |-> (proj_x == SAT_POS || proj_x == SAT_NEG
                                 || proj_x == '0))
        else $error("zero w result not saturated");

    // Overflow shows on at least one coordinate
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflowed |-> (proj_x == SAT_POS || proj_x == SAT_NEG
                                     || proj_y == SAT_POS || proj_y == SAT_NEG
                                     || proj_z == SAT_POS || proj_z == SAT_NEG))
        else $error("overflow without saturated coordinate");

endmodule

bind vertex_transform_divide_core vtd_checker u_vtd_checker (.*);
